// ===== rtl/core/rgb_led_brightness_register_writer_defines.svh =====
// Assertion macros for the RGB LED brightness register writer.
// Standalone header; included by the top level only.
`ifndef RGB_LED_BRIGHTNESS_REGISTER_WRITER_DEFINES_SVH
`define RGB_LED_BRIGHTNESS_REGISTER_WRITER_DEFINES_SVH

// Implication checked at every rising edge, muted while reset is held.
`define RLBW_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true while out of reset.
`define RLBW_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/rlbw_pkg.sv =====
// Shared types, constants and helper functions of the RGB LED brightness register writer.
// No dependencies.
package rlbw_pkg;

  localparam int LedCount = 4;
  localparam int LedW     = (LedCount > 1) ? $clog2(LedCount) : 1;
  localparam int SelW     = 3;
  localparam int LevelW   = 8;
  localparam int ProdW    = 2 * LevelW;
  localparam int CfgIdxW  = 2;

  localparam logic [LevelW-1:0] MaxRedRst    = 8'h5c;
  localparam logic [LevelW-1:0] MaxGreenRst  = 8'h38;
  localparam logic [LevelW-1:0] MaxBlueRst   = 8'h67;
  localparam logic [LevelW-1:0] BrightRst    = 8'hff;
  localparam logic [7:0]        BankEven     = 8'h15;
  localparam logic [7:0]        BankOdd      = 8'h18;

  localparam logic [CfgIdxW-1:0] CfgMaxRed   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgMaxGreen = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgMaxBlue  = 2'd2;

  localparam logic OpSetColour     = 1'b0;
  localparam logic OpSetBrightness = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL1,
    ST_DIV1,
    ST_MUL2,
    ST_PUSH
  } state_e;

  // Order of emission: blue, red, green; value is the register offset.
  typedef enum logic [1:0] {
    COL_BLUE  = 2'd0,
    COL_RED   = 2'd1,
    COL_GREEN = 2'd2
  } colour_e;

  typedef struct packed {
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
  } colour_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic            accept;
    logic            mul1;
    logic            div1;
    logic            mul2;
    logic            push;
    logic [LedW-1:0] led;
    colour_e         col;
    logic            last;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
  } status_t;

  // True when the select field addresses every LED.
  function automatic logic sel_all(input logic [SelW-1:0] sel);
    return {1'b0, sel} >= (SelW + 1)'(LedCount);
  endfunction

  // Exact floor(x / 255) for any x up to 255 * 255, i.e. any product of two 8-bit levels.
  function automatic logic [LevelW-1:0] div255(input logic [ProdW-1:0] x);
    logic [ProdW:0] s;
    s = {1'b0, x} + (ProdW + 1)'(x[ProdW-1:LevelW]) + (ProdW + 1)'(1);
    return s[ProdW-1:LevelW];
  endfunction

  function automatic logic ctrl_id(input logic [LedW-1:0] led);
    logic [SelW-1:0] l;
    l = SelW'(led);
    return l[1];
  endfunction

  function automatic logic [7:0] reg_addr(input logic [LedW-1:0] led, input colour_e col);
    return (led[0] ? BankOdd : BankEven) + {6'd0, col};
  endfunction

endpackage

// ===== rtl/core/rlbw_ctrl.sv =====
// Sequencer of the RGB LED brightness register writer: state machine and LED/colour counters.
// Depends on rlbw_pkg.
module rlbw_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     operation_i,
  input  logic [rlbw_pkg::SelW-1:0] led_select_i,
  input  rlbw_pkg::status_t        status_i,
  output logic                     in_ready_o,
  output rlbw_pkg::cmd_t           cmd_o
);
  import rlbw_pkg::*;

  state_e          state_q, state_d;
  logic [LedW-1:0] led_q, led_d;
  logic [LedW-1:0] end_q, end_d;
  colour_e         col_q, col_d;
  logic            last;

  assign last = (col_q == COL_GREEN) && (led_q == end_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_MUL1;
      ST_MUL1: state_d = ST_DIV1;
      ST_DIV1: state_d = ST_MUL2;
      ST_MUL2: state_d = ST_PUSH;
      ST_PUSH: begin
        if (status_i.out_free) state_d = last ? ST_IDLE : ST_MUL1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o        = '0;
    cmd_o.led    = led_q;
    cmd_o.col    = col_q;
    cmd_o.last   = last;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_MUL1: cmd_o.mul1 = 1'b1;
      ST_DIV1: cmd_o.div1 = 1'b1;
      ST_MUL2: cmd_o.mul2 = 1'b1;
      ST_PUSH: cmd_o.push = status_i.out_free;
      default: ;
    endcase
  end

  // counters: load the LED range on accept, advance on each push
  always_comb begin
    led_d = led_q;
    end_d = end_q;
    col_d = col_q;
    if (cmd_o.accept) begin
      col_d = COL_BLUE;
      if (operation_i == OpSetBrightness || sel_all(led_select_i)) begin
        led_d = '0;
        end_d = LedW'(LedCount - 1);
      end else begin
        led_d = led_select_i[LedW-1:0];
        end_d = led_select_i[LedW-1:0];
      end
    end else if (cmd_o.push) begin
      case (col_q)
        COL_BLUE:  col_d = COL_RED;
        COL_RED:   col_d = COL_GREEN;
        default: begin
          col_d = COL_BLUE;
          led_d = led_q + LedW'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      led_q   <= '0;
      end_q   <= '0;
      col_q   <= COL_BLUE;
    end else begin
      state_q <= state_d;
      led_q   <= led_d;
      end_q   <= end_d;
      col_q   <= col_d;
    end
  end

endmodule

// ===== rtl/core/rlbw_datapath.sv =====
// Datapath of the RGB LED brightness register writer: colour store, settings,
// shared multiplier, divide-by-255 and output register. Depends on rlbw_pkg.
module rlbw_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [rlbw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rlbw_pkg::LevelW-1:0]   cfg_data_i,
  input  logic                          operation_i,
  input  logic [rlbw_pkg::SelW-1:0]     led_select_i,
  input  logic [rlbw_pkg::LevelW-1:0]   red_level_i,
  input  logic [rlbw_pkg::LevelW-1:0]   green_level_i,
  input  logic [rlbw_pkg::LevelW-1:0]   blue_level_i,
  input  logic [rlbw_pkg::LevelW-1:0]   brightness_level_i,
  input  rlbw_pkg::cmd_t                cmd_i,
  output rlbw_pkg::status_t             status_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          controller_id_o,
  output logic [7:0]                    register_address_o,
  output logic [rlbw_pkg::LevelW-1:0]   current_code_o,
  output logic                          last_write_o
);
  import rlbw_pkg::*;

  colour_t           store_q [LedCount];
  logic [LevelW-1:0] max_red_q, max_green_q, max_blue_q;
  logic [LevelW-1:0] bright_q;
  logic [ProdW-1:0]  prod_q;
  logic [LevelW-1:0] dim_q;
  logic              out_valid_q;
  logic              ctrl_id_q, last_q;
  logic [7:0]        addr_q;
  logic [LevelW-1:0] code_q;

  colour_t           entry;
  logic [LevelW-1:0] level, max_sel, mul_a, mul_b;
  colour_t           wr_colour;

  assign entry     = store_q[cmd_i.led];
  assign wr_colour = '{red: red_level_i, green: green_level_i, blue: blue_level_i};

  always_comb begin
    case (cmd_i.col)
      COL_BLUE: begin
        level   = entry.blue;
        max_sel = max_blue_q;
      end
      COL_RED: begin
        level   = entry.red;
        max_sel = max_red_q;
      end
      default: begin
        level   = entry.green;
        max_sel = max_green_q;
      end
    endcase
  end

  // one multiplier, used for the brightness pass and the full-scale pass
  assign mul_a = cmd_i.mul1 ? level    : dim_q;
  assign mul_b = cmd_i.mul1 ? bright_q : max_sel;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul1 || cmd_i.mul2) prod_q <= mul_a * mul_b;
    if (cmd_i.div1) dim_q <= div255(prod_q);
  end

  // settings and stored state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_red_q   <= MaxRedRst;
      max_green_q <= MaxGreenRst;
      max_blue_q  <= MaxBlueRst;
      bright_q    <= BrightRst;
      for (int i = 0; i < LedCount; i++) store_q[i] <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CfgMaxRed:   max_red_q   <= cfg_data_i;
          CfgMaxGreen: max_green_q <= cfg_data_i;
          CfgMaxBlue:  max_blue_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.accept) begin
        if (operation_i == OpSetBrightness) begin
          bright_q <= brightness_level_i;
        end else if (sel_all(led_select_i)) begin
          for (int i = 0; i < LedCount; i++) store_q[i] <= wr_colour;
        end else begin
          store_q[led_select_i[LedW-1:0]] <= wr_colour;
        end
      end
    end
  end

  // output register
  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      ctrl_id_q <= ctrl_id(cmd_i.led);
      addr_q    <= reg_addr(cmd_i.led, cmd_i.col);
      code_q    <= div255(prod_q);
      last_q    <= cmd_i.last;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign controller_id_o    = ctrl_id_q;
  assign register_address_o = addr_q;
  assign current_code_o     = code_q;
  assign last_write_o       = last_q;

endmodule

// ===== rtl/core/rgb_led_brightness_register_writer.sv =====
// Top level of the RGB LED brightness register writer: sequencer plus datapath.
// Depends on rlbw_pkg, rlbw_ctrl, rlbw_datapath and the defines header.
//
// Turns set-colour and set-brightness requests into driver current register
// writes, one output beat per write. A set-colour beat stores the raw colour
// of one LED (or of all four when led_select is 4 or more) and emits blue,
// red, green writes for each LED touched; a set-brightness beat stores the
// new global brightness and emits all twelve writes, LED 0 first. Each code
// is level * brightness / 255, then * full-scale / 255, both truncating.
// The block works on one item at a time. Each write goes through the single
// shared 8x8 multiplier in order: multiply, divide, multiply, load output
// register; the load waits while the output side stalls. The output register
// lets the next write be computed while a finished one waits, and a new item
// is taken as soon as the last write has been loaded. The configuration
// port is always ready; write it only while the block is idle.
`include "rgb_led_brightness_register_writer_defines.svh"

module rgb_led_brightness_register_writer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rlbw_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rlbw_pkg::LevelW-1:0]   cfg_data_i,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [rlbw_pkg::SelW-1:0]     led_select_i,
  input  logic [rlbw_pkg::LevelW-1:0]   red_level_i,
  input  logic [rlbw_pkg::LevelW-1:0]   green_level_i,
  input  logic [rlbw_pkg::LevelW-1:0]   blue_level_i,
  input  logic [rlbw_pkg::LevelW-1:0]   brightness_level_i,
  // register write channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          controller_id_o,
  output logic [7:0]                    register_address_o,
  output logic [rlbw_pkg::LevelW-1:0]   current_code_o,
  output logic                          last_write_o
);
  import rlbw_pkg::*;

  cmd_t    cmd;
  status_t status;

  // settings are plain registers: always take the beat
  assign cfg_ready_o = 1'b1;

  rlbw_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .operation_i  (operation_i),
    .led_select_i (led_select_i),
    .status_i     (status),
    .in_ready_o   (in_ready_o),
    .cmd_o        (cmd)
  );

  rlbw_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .operation_i        (operation_i),
    .led_select_i       (led_select_i),
    .red_level_i        (red_level_i),
    .green_level_i      (green_level_i),
    .blue_level_i       (blue_level_i),
    .brightness_level_i (brightness_level_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .controller_id_o    (controller_id_o),
    .register_address_o (register_address_o),
    .current_code_o     (current_code_o),
    .last_write_o       (last_write_o)
  );

  // after taking a request the block is busy on the next cycle
  `RLBW_ASSERT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "request accepted while still busy")
  // a new write must never overwrite one that has not been taken
  `RLBW_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd.push && out_valid_o && !out_ready_i, "pending write overwritten")
  // only the six current registers are ever addressed
  `RLBW_ASSERT(a_addr_range, clk_i, rst_ni, out_valid_o |-> (register_address_o >= 8'h15) && (register_address_o <= 8'h1a), "register address out of range")

endmodule

// ===== test/rgb_led_brightness_register_writer_tb.sv =====
// Self-checking testbench for rgb_led_brightness_register_writer: directed table, then random
// requests, with every register write compared against a built-in colour/brightness predictor.
// Depends on rlbw_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module rgb_led_brightness_register_writer_tb;
  import rlbw_pkg::*;

  // Spare register index: decoded by nobody, must leave every full-scale code alone.
  localparam logic [CfgIdxW-1:0] CfgSpare = 2'd3;

  localparam int IdlePct     = 19;      // share of cycles each side idles, in percent
  localparam int SettleCycles = 8;      // block latency margin once the last write is out
  localparam int EndCycles   = 64;      // quiet time at the end of the run
  localparam int CycleLimit  = 200000;  // generous bound that aborts a hung run
  localparam int ReportLimit = 10;
  localparam int PhaseItems  = 26;
  localparam int RandPhases  = 6;
  localparam int NumDirected = 24;

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_e;

  // One table row. A config row writes red/green/blue full-scale codes from the level
  // fields and throws the brightness field at the spare index. A pinned code of -1 means
  // the predictor decides; otherwise every write of the request must carry that code.
  typedef struct packed {
    row_kind_e         kind;
    logic              op;
    logic [SelW-1:0]   sel;
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
    logic [LevelW-1:0] bright;
    int                pin;
  } stim_row_t;

  typedef struct packed {
    logic              op;
    logic [SelW-1:0]   sel;
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
    logic [LevelW-1:0] bright;
  } led_request_t;

  typedef struct packed {
    logic              ctrl;
    logic [7:0]        addr;
    logic [LevelW-1:0] code;
    logic              last;
  } reg_write_t;

  // Clock, reset and every block input start at a known value.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [LevelW-1:0]   cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic                op_d = OpSetColour;
  logic [SelW-1:0]     sel_d = '0;
  logic [LevelW-1:0]   red_d = '0;
  logic [LevelW-1:0]   green_d = '0;
  logic [LevelW-1:0]   blue_d = '0;
  logic [LevelW-1:0]   bright_d = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                ctrl_q;
  logic [7:0]          addr_q;
  logic [LevelW-1:0]   code_q;
  logic                last_q;

  // Predictor state: stored raw colours, global brightness and full-scale codes.
  colour_t             led_colour [LedCount];
  logic [LevelW-1:0]   brightness_q;
  logic [LevelW-1:0]   full_red_q;
  logic [LevelW-1:0]   full_green_q;
  logic [LevelW-1:0]   full_blue_q;

  reg_write_t          pending_writes [$];
  stim_row_t           directed_rows [NumDirected];

  bit                  steady = 1'b0;   // both sides stop idling while set
  int                  fail_count = 0;
  int                  requests_sent = 0;
  int                  writes_seen = 0;
  int                  cfg_writes = 0;
  int                  cycle_count = 0;

  rgb_led_brightness_register_writer i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .cfg_valid_i        (cfg_valid),
    .cfg_ready_o        (cfg_ready),
    .cfg_index_i        (cfg_index),
    .cfg_data_i         (cfg_data),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .operation_i        (op_d),
    .led_select_i       (sel_d),
    .red_level_i        (red_d),
    .green_level_i      (green_d),
    .blue_level_i       (blue_d),
    .brightness_level_i (bright_d),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .controller_id_o    (ctrl_q),
    .register_address_o (addr_q),
    .current_code_o     (code_q),
    .last_write_o       (last_q)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d writes outstanding", cycle_count,
               pending_writes.size());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic note_failure(input string what);
    fail_count++;
    if (fail_count <= ReportLimit) $display("[%0t] %s", $realtime, what);
  endtask

  // Level scaled by the brightness, then by the colour's full-scale code; both truncate.
  function automatic logic [LevelW-1:0] scaled_code(input logic [LevelW-1:0] level,
                                                    input logic [LevelW-1:0] full);
    int dimmed;
    dimmed = int'(level) * int'(brightness_q) / 255;
    return LevelW'(dimmed * int'(full) / 255);
  endfunction

  // Queue the blue, red, green writes of one LED; flag the green one when it ends the request.
  function automatic void queue_led_writes(input int led, input bit final_led, input int pin);
    reg_write_t w;
    logic [7:0] bank;
    bank = led[0] ? BankOdd : BankEven;
    w.ctrl = led[1];
    w.last = 1'b0;
    w.addr = bank + 8'(COL_BLUE);
    w.code = scaled_code(led_colour[led[LedW-1:0]].blue, full_blue_q);
    if (pin >= 0) w.code = LevelW'(pin);
    pending_writes.push_back(w);
    w.addr = bank + 8'(COL_RED);
    w.code = scaled_code(led_colour[led[LedW-1:0]].red, full_red_q);
    if (pin >= 0) w.code = LevelW'(pin);
    pending_writes.push_back(w);
    w.addr = bank + 8'(COL_GREEN);
    w.code = scaled_code(led_colour[led[LedW-1:0]].green, full_green_q);
    if (pin >= 0) w.code = LevelW'(pin);
    w.last = final_led;
    pending_writes.push_back(w);
  endfunction

  // Update the stored state for one accepted request and queue the writes it causes.
  function automatic void predict_writes(input led_request_t rq, input int pin);
    colour_t c;
    c.red   = rq.red;
    c.green = rq.green;
    c.blue  = rq.blue;
    if (rq.op == OpSetBrightness) begin
      brightness_q = rq.bright;
      for (int led = 0; led < LedCount; led++) queue_led_writes(led, led == LedCount - 1, pin);
    end else if (int'(rq.sel) >= LedCount) begin
      for (int led = 0; led < LedCount; led++) begin
        led_colour[led[LedW-1:0]] = c;
        queue_led_writes(led, led == LedCount - 1, pin);
      end
    end else begin
      led_colour[rq.sel[LedW-1:0]] = c;
      queue_led_writes(int'(rq.sel), 1'b1, pin);
    end
  endfunction

  // Present one request, after a random gap unless steady, and hold it until accepted.
  // On return the accepting edge has just passed and in_valid is still high, so the next
  // call either lowers it or replaces the payload, never both in one step.
  task automatic send_request(input led_request_t rq, input int pin);
    if (!steady && $urandom_range(99) < IdlePct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < IdlePct) @(posedge clk);
    end
    in_valid <= 1'b1;
    op_d     <= rq.op;
    sel_d    <= rq.sel;
    red_d    <= rq.red;
    green_d  <= rq.green;
    blue_d   <= rq.blue;
    bright_d <= rq.bright;
    do @(posedge clk); while (!in_ready);
    predict_writes(rq, pin);
    requests_sent++;
  endtask

  // Hold off the sender until every queued write has come out and the block has gone idle.
  task automatic drain_writes();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // One configuration beat; drop valid for a cycle afterwards.
  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [LevelW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CfgMaxRed:   full_red_q   = data;
      CfgMaxGreen: full_green_q = data;
      CfgMaxBlue:  full_blue_q  = data;
      default: ;
    endcase
    cfg_writes++;
    @(posedge clk);
  endtask

  task automatic write_full_scale(input logic [LevelW-1:0] red, input logic [LevelW-1:0] green,
                                  input logic [LevelW-1:0] blue, input logic [LevelW-1:0] spare);
    write_register(CfgMaxRed, red);
    write_register(CfgMaxGreen, green);
    write_register(CfgMaxBlue, blue);
    write_register(CfgSpare, spare);
  endtask

  // Favour the extremes: zero and full scale each turn up about one time in eight.
  function automatic logic [LevelW-1:0] pick_level();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return LevelW'($urandom);
    endcase
  endfunction

  function automatic led_request_t random_request();
    led_request_t rq;
    rq.op     = ($urandom_range(99) < 25) ? OpSetBrightness : OpSetColour;
    rq.sel    = SelW'($urandom_range(7));
    rq.red    = pick_level();
    rq.green  = pick_level();
    rq.blue   = pick_level();
    rq.bright = pick_level();
    return rq;
  endfunction

  // Result side: stall at random, check each accepted write against the oldest prediction.
  always @(posedge clk) begin
    reg_write_t want;
    if (rst_n && out_valid && out_ready) begin
      writes_seen++;
      if (pending_writes.size() == 0) begin
        note_failure($sformatf("unexpected write ctrl=%0d addr=%02h code=%02h last=%0d",
                               ctrl_q, addr_q, code_q, last_q));
      end else begin
        want = pending_writes.pop_front();
        if (ctrl_q !== want.ctrl || addr_q !== want.addr ||
            code_q !== want.code || last_q !== want.last) begin
          note_failure($sformatf(
            "write mismatch: expected ctrl=%0d addr=%02h code=%02h last=%0d, got %0d %02h %02h %0d",
            want.ctrl, want.addr, want.code, want.last, ctrl_q, addr_q, code_q, last_q));
        end
      end
    end
    out_ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  initial begin
    led_request_t rq;

    // Reset values of the predictor state.
    foreach (led_colour[i]) led_colour[i] = '0;
    brightness_q = BrightRst;
    full_red_q   = MaxRedRst;
    full_green_q = MaxGreenRst;
    full_blue_q  = MaxBlueRst;

    directed_rows = '{
      // Straight out of reset: black LED, then brightness over all-black store.
      '{ROW_REQ, OpSetColour,     3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 0},
      '{ROW_REQ, OpSetBrightness, 3'd0, 8'h00, 8'h00, 8'h00, 8'hff, 0},
      // Each LED on its own, both chips and both banks.
      '{ROW_REQ, OpSetColour,     3'd1, 8'hff, 8'hff, 8'hff, 8'h00, -1},
      '{ROW_REQ, OpSetColour,     3'd2, 8'h12, 8'h34, 8'h56, 8'hff, -1},
      '{ROW_REQ, OpSetColour,     3'd3, 8'h80, 8'h40, 8'hc0, 8'h01, -1},
      // All-LED selects, lowest and highest select value.
      '{ROW_REQ, OpSetColour,     3'd4, 8'hff, 8'h00, 8'h7f, 8'h33, -1},
      '{ROW_REQ, OpSetColour,     3'd7, 8'ha5, 8'h5a, 8'h3c, 8'hff, -1},
      // Brightness sweep; select and levels carry junk that must be ignored.
      '{ROW_REQ, OpSetBrightness, 3'd5, 8'hff, 8'hff, 8'hff, 8'h00, 0},
      '{ROW_REQ, OpSetBrightness, 3'd2, 8'h11, 8'h22, 8'h33, 8'h01, -1},
      '{ROW_REQ, OpSetBrightness, 3'd7, 8'h00, 8'hff, 8'h00, 8'h80, -1},
      '{ROW_REQ, OpSetBrightness, 3'd0, 8'haa, 8'h55, 8'haa, 8'hfe, -1},
      '{ROW_REQ, OpSetBrightness, 3'd4, 8'h00, 8'h00, 8'h00, 8'hff, -1},
      '{ROW_REQ, OpSetColour,     3'd0, 8'h00, 8'h00, 8'h00, 8'h55, -1},
      '{ROW_REQ, OpSetColour,     3'd6, 8'hff, 8'hff, 8'hff, 8'haa, -1},
      // Full-scale codes at maximum: white at full brightness gives all ones.
      '{ROW_CFG, OpSetColour,     3'd0, 8'hff, 8'hff, 8'hff, 8'h00, -1},
      '{ROW_REQ, OpSetColour,     3'd5, 8'hff, 8'hff, 8'hff, 8'h00, 8'hff},
      '{ROW_REQ, OpSetBrightness, 3'd0, 8'h00, 8'h00, 8'h00, 8'h00, 0},
      '{ROW_REQ, OpSetBrightness, 3'd0, 8'h00, 8'h00, 8'h00, 8'hff, 8'hff},
      // Full-scale codes at zero: everything reads zero.
      '{ROW_CFG, OpSetColour,     3'd0, 8'h00, 8'h00, 8'h00, 8'hff, -1},
      '{ROW_REQ, OpSetColour,     3'd2, 8'hff, 8'hff, 8'hff, 8'h00, 0},
      '{ROW_REQ, OpSetBrightness, 3'd0, 8'h00, 8'h00, 8'h00, 8'h7f, 0},
      // Odd full-scale codes, brightness left at 7f.
      '{ROW_CFG, OpSetColour,     3'd0, 8'h01, 8'h80, 8'hfe, 8'h5a, -1},
      '{ROW_REQ, OpSetColour,     3'd3, 8'hff, 8'h01, 8'h80, 8'hff, -1},
      '{ROW_REQ, OpSetColour,     3'd4, 8'h01, 8'hfe, 8'h55, 8'h00, -1}
    };

    // Hold reset, then release it on an edge.
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table; config rows wait for the block to empty first.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        drain_writes();
        write_full_scale(directed_rows[i].red, directed_rows[i].green,
                         directed_rows[i].blue, directed_rows[i].bright);
      end else begin
        rq.op     = directed_rows[i].op;
        rq.sel    = directed_rows[i].sel;
        rq.red    = directed_rows[i].red;
        rq.green  = directed_rows[i].green;
        rq.blue   = directed_rows[i].blue;
        rq.bright = directed_rows[i].bright;
        send_request(rq, directed_rows[i].pin);
      end
    end

    // Random phases, each under fresh full-scale codes; one phase runs with no idling.
    for (int phase = 0; phase < RandPhases; phase++) begin
      drain_writes();
      write_full_scale(pick_level(), pick_level(), pick_level(), pick_level());
      steady = (phase == 2);
      repeat (PhaseItems) begin
        rq = random_request();
        send_request(rq, -1);
      end
    end
    steady = 1'b0;

    // Let the last writes out, then give the block time to show anything spurious.
    drain_writes();
    repeat (EndCycles) @(posedge clk);
    if (pending_writes.size() != 0)
      note_failure($sformatf("%0d writes never arrived", pending_writes.size()));

    $display("covered %0d requests and %0d register writes under %0d config beats",
             requests_sent, writes_seen, cfg_writes);
    $display("single, all-LED and brightness requests with zero and full-scale codes; %0d errors",
             fail_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
